>>> rtl/chiptune_voice_synth_unit_defines.svh
// assertion macros for the tone generator rtl
`ifndef CHIPTUNE_VOICE_SYNTH_UNIT_DEFINES_SVH
`define CHIPTUNE_VOICE_SYNTH_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CVS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cvs_pkg.sv
// shared constants, types and the note-to-step table of the tone generator
`timescale 1ns / 1ps

package cvs_pkg;

    // sizing
    localparam int PHASE_BITS        = 24;
    localparam int SAMPLES_PER_FRAME = 1470;
    localparam int NUM_VOICES        = 3;
    localparam int VOICE_W           = $clog2(NUM_VOICES + 1);
    localparam int MAX_FRAMES        = 255;
    localparam int POS_W             = $clog2(MAX_FRAMES * SAMPLES_PER_FRAME + 1);

    // item codes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    // waveform codes
    localparam logic [1:0] WF_SQUARE     = 2'd0;
    localparam logic [1:0] WF_TRIANGLE   = 2'd1;
    localparam logic [1:0] WF_NOISE      = 2'd2;
    localparam logic [1:0] WF_SQUARE_ALT = 2'd3;

    localparam logic [VOICE_W-1:0] SYS_VOICE  = VOICE_W'(2);
    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(NUM_VOICES - 1);
    localparam logic [POS_W-1:0]   POS_MAX    = '1;

    // noise generator
    localparam logic [15:0] LFSR_SEED = 16'h0001;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // wave levels, Q1.15
    localparam logic signed [16:0] WAVE_POS = 17'sd32767;
    localparam logic signed [16:0] WAVE_NEG = -17'sd32767;

    // 14000 / 229376 reduces to 2000 / 2^15
    localparam int VOL_SCALE = 2000;
    localparam int SYS_GAIN  = 45875;
    localparam int ENV_ONE   = 65536;

    // envelope divide by the frame length via reciprocal multiply
    localparam int ENV_Y_W    = $clog2(2 * SAMPLES_PER_FRAME + 1);
    localparam int ENV_L      = $clog2(SAMPLES_PER_FRAME);
    localparam int ENV_K      = ENV_Y_W + 16 + ENV_L;
    localparam int ENV_M_W    = ENV_K - ENV_L + 1;
    localparam int ENV_PROD_W = ENV_Y_W + ENV_M_W;
    localparam int ENV_SHIFT  = ENV_K - 16;
    localparam int ENV_Q_W    = ENV_PROD_W - ENV_SHIFT;
    localparam longint unsigned ENV_M =
        ((64'd1 << ENV_K) + 64'(SAMPLES_PER_FRAME) - 64'd1) / 64'(SAMPLES_PER_FRAME);

    // datapath widths
    localparam int WV_W  = 31;
    localparam int ENV_W = 17;
    localparam int P_W   = 48;
    localparam int X_W   = 31;
    localparam int XG_W  = 48;
    localparam int C_W   = 32;
    localparam int SUM_W = 34;

    // one voice entry of the voice memory
    typedef struct packed {
        logic                  active;
        logic [2:0]            volume;
        logic [1:0]            waveform;
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] step;
        logic [POS_W-1:0]      position;
        logic [POS_W-1:0]      length;
    } t_voice_rec;

    typedef struct packed {
        logic               en;
        logic [VOICE_W-1:0] addr;
        t_voice_rec         rec;
    } t_wr_req;

    typedef struct packed {
        logic               vld;
        logic [VOICE_W-1:0] voice;
        logic               last;
    } t_rd_tag;

    typedef struct packed {
        logic vld;
        logic live;
        logic sys;
        logic last;
    } t_mix_tag;

    typedef enum logic [1:0] {
        ENV_FULL,
        ENV_ATTACK,
        ENV_RELEASE
    } t_env_mode;

    // top octave increments, notes 116..127
    localparam logic [31:0] TOP_OCT [12] = '{
        32'd647154683,  32'd685636503,  32'd726406571,  32'd769600953,
        32'd815363807,  32'd863847862,  32'd915214929,  32'd969636441,
        32'd1027294024, 32'd1088380105, 32'd1153098554, 32'd1221665363
    };

    // phase increment for a note, octave shift with rounding
    function automatic logic [PHASE_BITS-1:0] note_step(input logic [6:0] note);
        logic [6:0]  t;
        logic [14:0] t_mul;
        logic [3:0]  oct;
        logic [3:0]  rem;
        logic [3:0]  k;
        logic [5:0]  sh;
        logic [32:0] v;
        t     = 7'd127 - note;
        t_mul = 15'(t) * 15'd171;
        oct   = 4'(t_mul >> 11);
        rem   = 4'(t - 7'(oct) * 7'd12);
        k     = 4'd11 - rem;
        sh    = 6'(oct) + 6'(32 - PHASE_BITS);
        v     = {1'b0, TOP_OCT[k]};
        if (sh != 6'd0) begin
            v = v + (33'd1 << (sh - 6'd1));
        end
        return PHASE_BITS'(v >> sh);
    endfunction

endpackage

>>> rtl/cvs_voice_mem.sv
// voice state memory, one write and one registered read port
`timescale 1ns / 1ps

module cvs_voice_mem (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cvs_pkg::t_wr_req                  i_wr,
    input  logic                              i_rd_en,
    input  logic [cvs_pkg::VOICE_W-1:0]       i_rd_addr,
    output cvs_pkg::t_voice_rec               o_rd_rec
);
    import cvs_pkg::*;

    t_voice_rec r_mem [NUM_VOICES];
    logic       r_vld [NUM_VOICES];
    t_voice_rec r_rd_rec;

    // entry written flags, unwritten entries read as silent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOICES; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.rec;
        end
        if (i_rd_en) begin
            r_rd_rec <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_rec = r_rd_rec;

endmodule

>>> rtl/cvs_voice_update.sv
// per-voice update: end check, wave, envelope operand and write-back
`timescale 1ns / 1ps

module cvs_voice_update (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cvs_pkg::t_rd_tag                     i_tag,
    input  cvs_pkg::t_voice_rec                  i_rec,
    output cvs_pkg::t_wr_req                     o_wb,
    output cvs_pkg::t_mix_tag                    o_tag,
    output logic signed [cvs_pkg::WV_W-1:0]      o_wv,
    output cvs_pkg::t_env_mode                   o_env_mode,
    output logic [cvs_pkg::ENV_PROD_W-1:0]       o_env_prod
);
    import cvs_pkg::*;

    logic                   ended;
    logic                   live;
    logic                   is_sys;
    logic                   lfsr_bit;
    logic [15:0]            r_lfsr;
    logic [15:0]            n_lfsr;
    logic [15:0]            tri_u;
    logic signed [17:0]     tri_raw;
    logic signed [16:0]     wave;
    logic signed [14:0]     vol_k;
    logic signed [31:0]     wv_full;
    t_env_mode              env_mode;
    logic [ENV_Y_W-1:0]     env_y;
    logic [POS_W:0]         rel_reach;
    t_voice_rec             wb_rec;
    t_mix_tag               r_tag;
    logic signed [WV_W-1:0] r_wv;
    t_env_mode              r_env_mode;
    logic [ENV_PROD_W-1:0]  r_env_prod;

    // timed note that has run out
    assign ended  = (i_rec.length != '0) && (i_rec.position >= i_rec.length);
    assign live   = i_tag.vld && i_rec.active && !ended;
    assign is_sys = (i_tag.voice == SYS_VOICE);

    // noise shift register steps once per noise sample
    assign lfsr_bit = r_lfsr[0];
    always_comb begin
        n_lfsr = r_lfsr;
        if (live && (i_rec.waveform == WF_NOISE)) begin
            n_lfsr = (r_lfsr >> 1) ^ (lfsr_bit ? LFSR_TAPS : 16'h0000);
        end
    end

    // waveform sample
    assign tri_u = i_rec.phase[PHASE_BITS-1 -: 16];
    always_comb begin
        if (tri_u[15]) begin
            tri_raw = 18'sd98304 - $signed({1'b0, tri_u, 1'b0});
        end else begin
            tri_raw = $signed({1'b0, tri_u, 1'b0}) - 18'sd32768;
        end
        case (i_rec.waveform)
            WF_NOISE: begin
                wave = lfsr_bit ? WAVE_POS : WAVE_NEG;
            end
            WF_TRIANGLE: begin
                wave = (tri_raw > 18'sd32767) ? WAVE_POS : 17'(tri_raw);
            end
            default: begin
                wave = i_rec.phase[PHASE_BITS-1] ? WAVE_NEG : WAVE_POS;
            end
        endcase
    end

    // wave times scaled volume
    assign vol_k   = 15'(i_rec.volume * VOL_SCALE);
    assign wv_full = wave * vol_k;

    // system voice envelope: attack ramp first, then release ramp
    assign rel_reach = {1'b0, i_rec.position} + (POS_W + 1)'(2 * SAMPLES_PER_FRAME);
    always_comb begin
        env_mode = ENV_FULL;
        env_y    = '0;
        if (is_sys) begin
            if (i_rec.position < POS_W'(SAMPLES_PER_FRAME)) begin
                env_mode = ENV_ATTACK;
                env_y    = ENV_Y_W'(i_rec.position);
            end else if ((i_rec.length != '0) && (rel_reach >= {1'b0, i_rec.length})
                         && (i_rec.position < i_rec.length)) begin
                env_mode = ENV_RELEASE;
                env_y    = ENV_Y_W'(i_rec.length - i_rec.position);
            end
        end
    end

    // write-back record
    always_comb begin
        wb_rec        = i_rec;
        wb_rec.active = i_rec.active && !ended;
        if (live) begin
            if (i_rec.waveform != WF_NOISE) begin
                wb_rec.phase = i_rec.phase + i_rec.step;
            end
            if (i_rec.position != POS_MAX) begin
                wb_rec.position = i_rec.position + POS_W'(1);
            end
        end
    end

    assign o_wb.en   = i_tag.vld && i_rec.active;
    assign o_wb.addr = i_tag.voice;
    assign o_wb.rec  = wb_rec;

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag  <= '0;
            r_lfsr <= LFSR_SEED;
        end else begin
            r_tag.vld  <= i_tag.vld;
            r_tag.live <= live;
            r_tag.sys  <= is_sys;
            r_tag.last <= i_tag.last;
            r_lfsr     <= n_lfsr;
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        r_wv       <= WV_W'(wv_full);
        r_env_mode <= env_mode;
        r_env_prod <= ENV_PROD_W'(env_y) * ENV_PROD_W'(ENV_M);
    end

    assign o_tag      = r_tag;
    assign o_wv       = r_wv;
    assign o_env_mode = r_env_mode;
    assign o_env_prod = r_env_prod;

endmodule

>>> rtl/cvs_mix_pipe.sv
// envelope, gain, accumulate and saturate pipeline
`timescale 1ns / 1ps

module cvs_mix_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  cvs_pkg::t_mix_tag                 i_tag,
    input  logic signed [cvs_pkg::WV_W-1:0]   i_wv,
    input  cvs_pkg::t_env_mode                i_env_mode,
    input  logic [cvs_pkg::ENV_PROD_W-1:0]    i_env_prod,
    output logic                              o_done,
    output logic signed [15:0]                o_res
);
    import cvs_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    logic [ENV_Q_W-1:0]      env_q;
    logic [ENV_W-1:0]        env;
    logic signed [P_W-1:0]   p_adj;
    logic signed [X_W-1:0]   x;
    logic signed [16:0]      gain_s;
    logic signed [XG_W-1:0]  xg_sys;
    logic signed [XG_W-1:0]  xg_one;
    logic signed [XG_W-1:0]  xg_adj;
    logic signed [C_W-1:0]   c;
    logic signed [SUM_W-1:0] s_adj;
    logic signed [SUM_W-1:0] s_q;
    logic signed [15:0]      res;

    t_mix_tag                r_e_tag;
    logic signed [WV_W-1:0]  r_e_wv;
    logic [ENV_W-1:0]        r_e_env;
    t_mix_tag                r_p_tag;
    logic signed [P_W-1:0]   r_p;
    t_mix_tag                r_g_tag;
    logic signed [XG_W-1:0]  r_xg;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_f_go;
    logic                    r_done;
    logic signed [15:0]      r_res;

    // envelope quotient from the reciprocal product
    assign env_q = ENV_Q_W'(i_env_prod >> ENV_SHIFT);
    always_comb begin
        case (i_env_mode)
            ENV_ATTACK:  env = ENV_W'(env_q);
            ENV_RELEASE: env = ENV_W'(env_q >> 1);
            default:     env = ENV_W'(ENV_ONE);
        endcase
    end

    // divide by 2^15 toward zero, then system gain (unity for other voices)
    assign p_adj  = r_p + (r_p[P_W-1] ? P_W'(32767) : '0);
    assign x      = X_W'(p_adj >>> 15);
    assign gain_s = 17'(SYS_GAIN);
    assign xg_sys = x * gain_s;
    assign xg_one = XG_W'(x) <<< 16;

    // drop the gain fraction toward zero
    assign xg_adj = r_xg + (r_xg[XG_W-1] ? XG_W'(65535) : '0);
    assign c      = C_W'(xg_adj >>> 16);

    // final scale and clamp to 16 bits
    assign s_adj = r_sum + (r_sum[SUM_W-1] ? SUM_W'(65535) : '0);
    assign s_q   = s_adj >>> 16;
    always_comb begin
        if (s_q > SAT_HI) begin
            res = 16'sh7FFF;
        end else if (s_q < SAT_LO) begin
            res = -16'sh8000;
        end else begin
            res = 16'(s_q);
        end
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_tag <= '0;
            r_p_tag <= '0;
            r_g_tag <= '0;
            r_f_go  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_e_tag <= i_tag;
            r_p_tag <= r_e_tag;
            r_g_tag <= r_p_tag;
            r_f_go  <= r_g_tag.vld && r_g_tag.last;
            r_done  <= r_f_go;
        end
    end

    // stage data and accumulator
    always_ff @(posedge i_clk) begin
        r_e_wv  <= i_wv;
        r_e_env <= env;
        r_p     <= r_e_wv * $signed({1'b0, r_e_env});
        r_xg    <= r_p_tag.sys ? xg_sys : xg_one;
        if (i_start) begin
            r_sum <= '0;
        end else if (r_g_tag.vld && r_g_tag.live) begin
            r_sum <= r_sum + SUM_W'(c);
        end
        if (r_f_go) begin
            r_res <= res;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> rtl/chiptune_voice_synth_unit.sv
// Three-voice square/triangle/noise tone generator, top level.
//
// Input channel (i_in_valid / o_in_stall) takes one item per transaction.
// A trigger item (i_op = 1) loads a voice at the accept edge; the
// next item can be accepted on the following clock. A trigger on voice 3
// is dropped. A sample item (i_op = 0) steps all three voices and yields
// one transaction on the output channel (o_out_valid / i_out_stall).
// Sample flow: the voices go through a read-modify-write of the voice
// memory one voice per cycle (one read port), then a five-stage multiply
// and accumulate pipe. The sample is loaded into the output register as
// the sequencer returns to idle, and the next item can be taken in the
// cycle after that when the output is not stalled.
// While the receiver stalls, the held sample stays put and the block
// keeps taking items; a further sample waits, with o_in_stall high,
// until the output register frees up.
// Reset (synchronous, active low) silences all voices, reseeds the noise
// register and empties the output register; there is no clearing pass.
`timescale 1ns / 1ps
`include "chiptune_voice_synth_unit_defines.svh"

module chiptune_voice_synth_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [1:0]         i_voice,
    input  logic [6:0]         i_note,
    input  logic [2:0]         i_volume,
    input  logic [1:0]         i_waveform,
    input  logic signed [8:0]  i_duration_frames,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample
);
    import cvs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [VOICE_W-1:0]   r_rd_voice;
    t_rd_tag              r_rd_tag;
    logic                 r_out_valid;
    logic signed [15:0]   r_out_sample;

    logic                 in_accept;
    logic                 sample_start;
    logic                 out_free;
    logic                 out_load;
    logic                 is_sys_trig;
    logic                 dur_pos;
    t_wr_req              trig_wr;
    t_wr_req              mem_wr;
    t_wr_req              upd_wb;
    logic                 rd_en;
    t_voice_rec           rd_rec;
    t_mix_tag             upd_tag;
    logic signed [WV_W-1:0] upd_wv;
    t_env_mode            upd_env_mode;
    logic [ENV_PROD_W-1:0] upd_env_prod;
    logic                 mix_done;
    logic signed [15:0]   mix_res;

    // input handshake
    assign o_in_stall   = (r_state != S_IDLE);
    assign in_accept    = i_in_valid && (r_state == S_IDLE);
    assign sample_start = in_accept && (i_op == OP_SAMPLE);

    // trigger record, written at the accept edge
    assign is_sys_trig = (i_voice == SYS_VOICE);
    assign dur_pos     = !i_duration_frames[8] && (i_duration_frames != 9'sd0);
    always_comb begin
        trig_wr.en              = in_accept && (i_op == OP_TRIGGER)
                                  && (i_voice < VOICE_W'(NUM_VOICES));
        trig_wr.addr            = i_voice;
        trig_wr.rec.active      = (i_note != 7'd0)
                                  && !(is_sys_trig && (i_duration_frames == 9'sd0));
        trig_wr.rec.volume      = i_volume;
        if (is_sys_trig) begin
            trig_wr.rec.waveform = WF_TRIANGLE;
        end else if (i_waveform == WF_SQUARE_ALT) begin
            trig_wr.rec.waveform = WF_SQUARE;
        end else begin
            trig_wr.rec.waveform = i_waveform;
        end
        trig_wr.rec.phase    = '0;
        trig_wr.rec.step     = note_step(i_note);
        trig_wr.rec.position = '0;
        trig_wr.rec.length   = dur_pos ? POS_W'(i_duration_frames[7:0])
                                         * POS_W'(SAMPLES_PER_FRAME) : '0;
    end

    // one memory write port: triggers when idle, write-back during a sample
    assign mem_wr = trig_wr.en ? trig_wr : upd_wb;
    assign rd_en  = (r_state == S_READ);

    // output register
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = ((r_state == S_DRAIN) && mix_done) || (r_state == S_OUT);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (sample_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_rd_voice == LAST_VOICE) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (mix_done) begin
                    n_state = out_free ? S_IDLE : S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer state, read tag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_tag.vld <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_tag.vld <= rd_en;
            if (out_load && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_rd_tag.voice <= r_rd_voice;
        r_rd_tag.last  <= (r_rd_voice == LAST_VOICE);
        if (sample_start) begin
            r_rd_voice <= '0;
        end else if (rd_en) begin
            r_rd_voice <= r_rd_voice + VOICE_W'(1);
        end
        if (out_load && out_free) begin
            r_out_sample <= mix_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;

    cvs_voice_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_voice),
        .o_rd_rec  (rd_rec)
    );

    cvs_voice_update u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (r_rd_tag),
        .i_rec      (rd_rec),
        .o_wb       (upd_wb),
        .o_tag      (upd_tag),
        .o_wv       (upd_wv),
        .o_env_mode (upd_env_mode),
        .o_env_prod (upd_env_prod)
    );

    cvs_mix_pipe u_mix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sample_start),
        .i_tag      (upd_tag),
        .i_wv       (upd_wv),
        .i_env_mode (upd_env_mode),
        .i_env_prod (upd_env_prod),
        .o_done     (mix_done),
        .o_res      (mix_res)
    );

    // checks
    `CVS_ASSERT_SAME(a_no_same_entry, i_clk, i_rst_n, mem_wr.en && rd_en, mem_wr.addr != r_rd_voice, "write-back and read hit the same voice entry")
    `CVS_ASSERT_SAME(a_wr_exclusive, i_clk, i_rst_n, trig_wr.en, !upd_wb.en, "trigger write collides with voice write-back")
    `CVS_ASSERT_SAME(a_done_in_drain, i_clk, i_rst_n, mix_done, r_state == S_DRAIN, "mix result arrived outside the drain state")
    `CVS_ASSERT_NEXT(a_res_held, i_clk, i_rst_n, mix_done && !out_free, (r_state == S_OUT) && $stable(mix_res), "pending mix result not held")

endmodule
